/* rtl/led_driver_bus_sniffer_macros.svh */
// Assertion helpers for the bus sniffer.
`ifndef LED_DRIVER_BUS_SNIFFER_MACROS_SVH
`define LED_DRIVER_BUS_SNIFFER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbs assertion failed");

// Next-cycle implication, disabled in reset.
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbs assertion failed");

`endif

/* rtl/lbs_pkg.sv */
package lbs_pkg;

  localparam int RUN_COUNT_WIDTH  = 20;
  localparam int SYNC_HOLD_WIDTH  = 20;
  localparam int CFG_INDEX_WIDTH  = 8;
  localparam int BYTE_WIDTH       = 8;
  localparam int BIT_CNT_WIDTH    = 4;
  localparam int NUM_DIGITS       = 10;
  localparam int IN_TDATA_WIDTH   = 8;
  localparam int OUT_TDATA_WIDTH  = 16;

  localparam logic [SYNC_HOLD_WIDTH-1:0] SYNC_HOLD_RESET = 20'd50000;
  localparam logic [BYTE_WIDTH-1:0]      MIN_BYTE_RESET  = 8'd114;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYNC_HOLD = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_BYTE  = 8'd1;

  typedef enum logic [1:0] {
    CLASS_LOW     = 2'd0,
    CLASS_RISING  = 2'd1,
    CLASS_FALLING = 2'd2,
    CLASS_HIGH    = 2'd3
  } lbs_class_e;

  localparam logic [BYTE_WIDTH-1:0] SEG_TABLE [2*NUM_DIGITS] = '{
    8'd223, 8'd134, 8'd189, 8'd183, 8'd230, 8'd119, 8'd127, 8'd199, 8'd255, 8'd247,
    8'd219, 8'd130, 8'd185, 8'd179, 8'd226, 8'd115, 8'd123, 8'd131, 8'd251, 8'd243
  };

  typedef struct packed {
    logic dio;
    logic clk;
    logic stb;
  } lbs_sample_t;

  typedef struct packed {
    logic synced;
    logic clk_rise;
    logic dio;
  } lbs_edge_t;

  typedef struct packed {
    logic                  alt_pattern;
    logic [3:0]            digit;
    logic                  digit_found;
    logic [BYTE_WIDTH-1:0] byte_value;
  } lbs_result_t;

  function automatic lbs_result_t lbs_decode(input logic [BYTE_WIDTH-1:0] value);
    lbs_result_t res;
    res             = '0;
    res.byte_value  = value;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (SEG_TABLE[NUM_DIGITS + i] == value) begin
        res.digit_found = 1'b1;
        res.digit       = 4'(i);
        res.alt_pattern = 1'b1;
      end
    end
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (SEG_TABLE[i] == value) begin
        res.digit_found = 1'b1;
        res.digit       = 4'(i);
        res.alt_pattern = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/lbs_edge.sv */
module lbs_edge #(
  parameter int RunCountWidth = lbs_pkg::RUN_COUNT_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  lbs_pkg::lbs_sample_t                 sample_i,
  input  logic [lbs_pkg::SYNC_HOLD_WIDTH-1:0]  sync_hold_i,
  output lbs_pkg::lbs_edge_t                   status_o
);
  import lbs_pkg::*;

  localparam int CmpWidth = (RunCountWidth > SYNC_HOLD_WIDTH) ? RunCountWidth
                                                               : SYNC_HOLD_WIDTH;

  logic                     stb_last_q, stb_last_d;
  lbs_class_e               stb_class_q, stb_class_d;
  logic [RunCountWidth-1:0] run_q, run_d;
  logic                     clk_last_q, clk_last_d;
  logic                     synced_q, synced_d;
  lbs_class_e               clk_class;
  logic                     sync_now;

  always_comb begin
    stb_class_d = lbs_class_e'({stb_last_q, sample_i.stb});
    run_d       = run_q;
    if (stb_class_d != stb_class_q) begin
      run_d = RunCountWidth'(1);
    end else if (run_q != {RunCountWidth{1'b1}}) begin
      run_d = run_q + RunCountWidth'(1);
    end
    stb_last_d = sample_i.stb;
    clk_last_d = sample_i.clk;
    clk_class  = lbs_class_e'({clk_last_q, sample_i.clk});
    sync_now   = (stb_class_d == CLASS_FALLING) &&
                 (CmpWidth'(run_q) > CmpWidth'(sync_hold_i));
    synced_d   = synced_q | sync_now;

    status_o.synced   = synced_d;
    status_o.clk_rise = (clk_class == CLASS_RISING);
    status_o.dio      = sample_i.dio;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_last_q  <= 1'b0;
      stb_class_q <= CLASS_LOW;
      run_q       <= '0;
      clk_last_q  <= 1'b0;
      synced_q    <= 1'b0;
    end else if (advance_i) begin
      stb_last_q  <= stb_last_d;
      stb_class_q <= stb_class_d;
      run_q       <= run_d;
      clk_last_q  <= clk_last_d;
      synced_q    <= synced_d;
    end
  end

endmodule

/* rtl/lbs_byte.sv */
module lbs_byte (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  lbs_pkg::lbs_edge_t              edge_i,
  input  logic [lbs_pkg::BYTE_WIDTH-1:0]  min_byte_i,
  output lbs_pkg::lbs_result_t            result_o,
  output logic                            result_valid_o
);
  import lbs_pkg::*;

  localparam logic [BIT_CNT_WIDTH-1:0] FullCount = BIT_CNT_WIDTH'(BYTE_WIDTH);

  logic [BIT_CNT_WIDTH-1:0] bit_cnt_q, bit_cnt_d, base_cnt;
  logic [BYTE_WIDTH-1:0]    shift_q, shift_d, base_shift;
  logic                     shift_en, flush;

  always_comb begin
    shift_en   = edge_i.synced && edge_i.clk_rise;
    flush      = shift_en && (bit_cnt_q >= FullCount);
    base_cnt   = flush ? '0 : bit_cnt_q;
    base_shift = flush ? '0 : shift_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    if (shift_en) begin
      shift_d   = base_shift |
                  (BYTE_WIDTH'(edge_i.dio) << base_cnt[$clog2(BYTE_WIDTH)-1:0]);
      bit_cnt_d = base_cnt + BIT_CNT_WIDTH'(1);
    end
    result_valid_o = flush && (shift_q > min_byte_i);
    result_o       = lbs_decode(shift_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      shift_q   <= '0;
    end else if (advance_i) begin
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
    end
  end

endmodule

/* rtl/led_driver_bus_sniffer.sv */
// Path: an accepted sample waits in the input register; its result, if any, is then
// stored in the result register that drives m_axis. Throughput: one sample per cycle
// unless m_axis stalls, set by those two registers and the combinational edge and byte logic between them.
// Reset: asynchronous, active low; clears sync, edge history, run count and the
// byte assembler, and loads the register defaults (hold 50000, min byte 114).
`include "led_driver_bus_sniffer_macros.svh"

module led_driver_bus_sniffer #(
  parameter int RunCountWidth = lbs_pkg::RUN_COUNT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [0] stb_level, [1] clk_level, [2] dio_level, [7:3] ignored
  input  logic [lbs_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] byte_value, [8] digit_found, [12:9] digit, [13] alt_pattern, [15:14] zero
  output logic [lbs_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lbs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [lbs_pkg::SYNC_HOLD_WIDTH-1:0]   cfg_data_i
);
  import lbs_pkg::*;

  logic                       in_valid_q;
  lbs_sample_t                in_sample_q;
  logic                       out_valid_q;
  lbs_result_t                out_q;
  logic [SYNC_HOLD_WIDTH-1:0] sync_hold_q;
  logic [BYTE_WIDTH-1:0]      min_byte_q;
  logic                       advance;
  lbs_edge_t                  edge_status;
  lbs_result_t                result;
  logic                       result_valid;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_WIDTH - $bits(lbs_result_t)){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_hold_q <= SYNC_HOLD_RESET;
      min_byte_q  <= MIN_BYTE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SYNC_HOLD: sync_hold_q <= cfg_data_i;
        REG_MIN_BYTE:  min_byte_q  <= cfg_data_i[BYTE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= s_axis_tdata[$bits(lbs_sample_t)-1:0];
    end
  end

  lbs_edge #(
    .RunCountWidth(RunCountWidth)
  ) u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .sample_i   (in_sample_q),
    .sync_hold_i(sync_hold_q),
    .status_o   (edge_status)
  );

  lbs_byte u_byte (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .edge_i        (edge_status),
    .min_byte_i    (min_byte_q),
    .result_o      (result),
    .result_valid_o(result_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result_valid) begin
      out_q <= result;
    end
  end

  `LBS_ASSERT_NOW(a_result_needs_sync, clk_i, rst_ni, advance && result_valid, edge_status.synced)
  `LBS_ASSERT_NOW(a_digit_range, clk_i, rst_ni, out_valid_q && out_q.digit_found, out_q.digit < 4'd10)
  `LBS_ASSERT_NOW(a_no_match_clear, clk_i, rst_ni, out_valid_q && !out_q.digit_found, (out_q.digit == 4'd0) && !out_q.alt_pattern)
  `LBS_ASSERT_NEXT(a_held_result, clk_i, rst_ni, out_valid_q && !m_axis_tready, out_valid_q && $stable(out_q))

endmodule
